// ===== sv/assert_macros.svh =====
// Assertion macros shared by the row deframer modules.
// Each macro expects a signal named clk, and ASSERT_CLK also rst_n, in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/drfd_pkg.sv =====
// Shared types and constants for the row field deframer.
// No dependencies; used by every module of the block.
package drfd_pkg;

  localparam logic [31:0] NULL_LENGTH = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    PH_COUNT_HI = 2'd0,
    PH_COUNT_LO = 2'd1,
    PH_LENGTH   = 2'd2,
    PH_PAYLOAD  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD   = 2'd0,
    KIND_NULL      = 2'd1,
    KIND_EMPTY     = 2'd2,
    KIND_EMPTY_ROW = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  out_byte;
    logic [14:0] field_index;
    logic        field_last;
    logic        row_last;
  } res_t;

endpackage

// ===== sv/drfd_parser.sv =====
// Parser state machine of the row field deframer: count, length headers, payload.
// Depends on drfd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module drfd_parser (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,      // a request is accepted this cycle
  input  logic [7:0]     in_byte,
  output logic           res_valid, // the accepted byte yields a result
  output drfd_pkg::res_t res
);

  drfd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  count_high_r, count_high_nxt;
  logic [14:0] fields_total_r, fields_total_nxt;
  logic [14:0] field_number_r, field_number_nxt;
  logic [31:0] length_shift_r, length_shift_nxt;
  logic [1:0]  hdr_pos_r, hdr_pos_nxt;
  logic [31:0] bytes_rem_r, bytes_rem_nxt;

  logic [15:0] count;
  logic [31:0] length_full;
  logic        last_field;
  logic        end_payload;
  logic [14:0] field_inc;

  assign count       = {count_high_r, in_byte};
  assign length_full = {length_shift_r[23:0], in_byte};
  assign field_inc   = field_number_r + 15'd1;
  assign last_field  = (field_inc == fields_total_r);
  assign end_payload = (bytes_rem_r == 32'd1);

  // Next state.
  always_comb begin
    phase_nxt        = phase_r;
    count_high_nxt   = count_high_r;
    fields_total_nxt = fields_total_r;
    field_number_nxt = field_number_r;
    length_shift_nxt = length_shift_r;
    hdr_pos_nxt      = hdr_pos_r;
    bytes_rem_nxt    = bytes_rem_r;
    unique case (phase_r)
      drfd_pkg::PH_COUNT_HI: begin
        count_high_nxt = in_byte;
        phase_nxt      = drfd_pkg::PH_COUNT_LO;
      end
      drfd_pkg::PH_COUNT_LO: begin
        field_number_nxt = '0;
        if (count[15] || count == 16'd0) begin
          fields_total_nxt = '0;
          phase_nxt        = drfd_pkg::PH_COUNT_HI;
        end else begin
          fields_total_nxt = count[14:0];
          hdr_pos_nxt      = '0;
          length_shift_nxt = '0;
          phase_nxt        = drfd_pkg::PH_LENGTH;
        end
      end
      drfd_pkg::PH_LENGTH: begin
        length_shift_nxt = length_full;
        if (hdr_pos_r != 2'd3) begin
          hdr_pos_nxt = hdr_pos_r + 2'd1;
        end else begin
          hdr_pos_nxt = '0;
          if (length_full == drfd_pkg::NULL_LENGTH || length_full == 32'd0) begin
            length_shift_nxt = '0;
            bytes_rem_nxt    = '0;
            if (last_field) begin
              phase_nxt        = drfd_pkg::PH_COUNT_HI;
              field_number_nxt = '0;
            end else begin
              field_number_nxt = field_inc;
            end
          end else begin
            bytes_rem_nxt = length_full;
            phase_nxt     = drfd_pkg::PH_PAYLOAD;
          end
        end
      end
      drfd_pkg::PH_PAYLOAD: begin
        bytes_rem_nxt = bytes_rem_r - 32'd1;
        if (end_payload) begin
          hdr_pos_nxt      = '0;
          length_shift_nxt = '0;
          if (last_field) begin
            phase_nxt        = drfd_pkg::PH_COUNT_HI;
            field_number_nxt = '0;
          end else begin
            field_number_nxt = field_inc;
            phase_nxt        = drfd_pkg::PH_LENGTH;
          end
        end
      end
      default: phase_nxt = drfd_pkg::PH_COUNT_HI;
    endcase
  end

  // Result for the byte at the input.
  always_comb begin
    res_valid       = 1'b0;
    res.kind        = drfd_pkg::KIND_PAYLOAD;
    res.out_byte    = '0;
    res.field_index = field_number_r;
    res.field_last  = 1'b1;
    res.row_last    = last_field;
    unique case (phase_r)
      drfd_pkg::PH_COUNT_LO: begin
        if (count[15] || count == 16'd0) begin
          res_valid       = 1'b1;
          res.kind        = drfd_pkg::KIND_EMPTY_ROW;
          res.field_index = '0;
          res.field_last  = 1'b0;
          res.row_last    = 1'b1;
        end
      end
      drfd_pkg::PH_LENGTH: begin
        if (hdr_pos_r == 2'd3 && length_full == 32'd0) begin
          res_valid = 1'b1;
          res.kind  = drfd_pkg::KIND_EMPTY;
        end else if (hdr_pos_r == 2'd3 && length_full == drfd_pkg::NULL_LENGTH) begin
          res_valid = 1'b1;
          res.kind  = drfd_pkg::KIND_NULL;
        end
      end
      drfd_pkg::PH_PAYLOAD: begin
        res_valid      = 1'b1;
        res.out_byte   = in_byte;
        res.field_last = end_payload;
        res.row_last   = end_payload && last_field;
      end
      default: res_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= drfd_pkg::PH_COUNT_HI;
      count_high_r   <= '0;
      fields_total_r <= '0;
      field_number_r <= '0;
      length_shift_r <= '0;
      hdr_pos_r      <= '0;
      bytes_rem_r    <= '0;
    end else if (step) begin
      phase_r        <= phase_nxt;
      count_high_r   <= count_high_nxt;
      fields_total_r <= fields_total_nxt;
      field_number_r <= field_number_nxt;
      length_shift_r <= length_shift_nxt;
      hdr_pos_r      <= hdr_pos_nxt;
      bytes_rem_r    <= bytes_rem_nxt;
    end
  end

  // A payload phase always has bytes still due.
  `ASSERT_CLK(a_payload_nonzero, phase_r != drfd_pkg::PH_PAYLOAD || bytes_rem_r != 32'd0,
    "payload phase with no bytes remaining")
  // The header byte position only moves while a length is being read.
  `ASSERT_CLK(a_hdr_pos_phase, phase_r == drfd_pkg::PH_LENGTH || hdr_pos_r == 2'd0,
    "length header position left nonzero outside the length phase")
  // Inside a row the current field index stays below the field count.
  `ASSERT_CLK(a_field_in_range,
    (phase_r != drfd_pkg::PH_LENGTH && phase_r != drfd_pkg::PH_PAYLOAD) ||
    field_number_r < fields_total_r, "field index beyond the field count")

endmodule

// ===== sv/drfd_out_reg.sv =====
// Result register of the row field deframer with its stream handshake.
// Depends on drfd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module drfd_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,      // an accepted request produced a result
  input  drfd_pkg::res_t res,
  input  logic           take,      // downstream takes the held result
  output logic           full,
  output drfd_pkg::res_t held
);

  logic           full_r, full_nxt;
  drfd_pkg::res_t held_r;

  assign full_nxt = load || (full_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else begin
      full_r <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_r <= res;
    end
  end

  assign full = full_r;
  assign held = held_r;

  // Marker results never carry a data byte.
  `ASSERT_CLK(a_marker_byte_zero,
    !full_r || held_r.kind == drfd_pkg::KIND_PAYLOAD || held_r.out_byte == 8'd0,
    "marker result with a nonzero byte")
  // An empty row marker always ends the row.
  `ASSERT_CLK(a_empty_row_last,
    !full_r || held_r.kind != drfd_pkg::KIND_EMPTY_ROW || held_r.row_last,
    "empty row marker without row end")

endmodule

// ===== sv/data_row_field_deframer.sv =====
// Row field deframer: splits the body of a database row message into tagged
// payload bytes and field markers. One input byte is taken per clock cycle,
// sustained while output keeps up; each byte yields at most one result from
// the result register. The body opens with a big-endian 16-bit field count (a
// count with its top bit set counts as zero), then each field carries a
// big-endian 32-bit length; all ones marks a null field, zero an empty field,
// and any other length is followed by that many payload bytes. A row with no
// fields yields one empty row marker. After the last field, the next byte
// begins a new row. The only thing that holds back input is a result still
// waiting in the result register while the output side is stalled; the
// parser state itself is updated in the cycle a request is accepted.
// Depends on drfd_pkg, drfd_parser and drfd_out_reg.

module data_row_field_deframer (
  input  logic        clk,
  input  logic        rst_n,
  // Input byte stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] out_byte, [22:8] field_index, [23] zero
  output logic [2:0]  out_tuser,  // [1:0] kind, [2] field_last
  output logic        out_tlast   // row_last
);

  logic           in_accept;
  logic           res_valid;
  drfd_pkg::res_t res;
  logic           full;
  drfd_pkg::res_t held;

  // A new request is taken whenever the result register is empty or is being
  // emptied in the same cycle.
  assign in_tready = !full || out_tready;
  assign in_accept = in_tvalid && in_tready;

  drfd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_accept),
    .in_byte   (in_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  drfd_out_reg u_out_reg (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (in_accept && res_valid),
    .res   (res),
    .take  (out_tready),
    .full  (full),
    .held  (held)
  );

  assign out_tvalid = full;
  assign out_tdata  = {1'b0, held.field_index, held.out_byte};
  assign out_tuser  = {held.field_last, held.kind};
  assign out_tlast  = held.row_last;

endmodule

// ===== dv/tb_data_row_field_deframer.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for data_row_field_deframer: row-body byte stimulus,
// a cycle-level predictor in a scoreboard class, and random stalls on both sides.
// Depends on drfd_pkg and the RTL of the block.

// Keeps its own copy of the parser state. Each accepted input byte advances it
// and may queue one expected result. Each accepted result is checked against
// the oldest queued one.
class row_scoreboard;
  drfd_pkg::phase_t phase;
  logic [7:0]       count_hi;
  logic [14:0]      fields_total;
  logic [14:0]      field_number;
  logic [31:0]      length_acc;
  logic [1:0]       hdr_pos;
  logic [31:0]      remaining;
  drfd_pkg::res_t   expected_q[$];
  int               errors;

  function new();
    phase        = drfd_pkg::PH_COUNT_HI;
    count_hi     = '0;
    fields_total = '0;
    field_number = '0;
    length_acc   = '0;
    hdr_pos      = '0;
    remaining    = '0;
    errors       = 0;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void queue_result(drfd_pkg::kind_t k, logic [7:0] b, logic [14:0] idx,
                             logic fl, logic rl);
    drfd_pkg::res_t r;
    r.kind        = k;
    r.out_byte    = b;
    r.field_index = idx;
    r.field_last  = fl;
    r.row_last    = rl;
    expected_q.push_back(r);
  endfunction

  function logic on_last_field();
    logic [14:0] nxt;
    nxt = field_number + 15'd1;
    return nxt == fields_total;
  endfunction

  // Step past the current field, to the next length header or to a new row.
  function void close_field(logic last);
    hdr_pos    = '0;
    length_acc = '0;
    remaining  = '0;
    if (last) begin
      phase        = drfd_pkg::PH_COUNT_HI;
      field_number = '0;
    end else begin
      field_number = field_number + 15'd1;
      phase        = drfd_pkg::PH_LENGTH;
    end
  endfunction

  function void note_request(logic [7:0] b);
    logic [15:0] count;
    logic        last;
    logic        end_field;
    case (phase)
      drfd_pkg::PH_COUNT_LO: begin
        count = {count_hi, b};
        // A negative count is handled like a zero count.
        if (count[15] || count == 16'd0) begin
          queue_result(drfd_pkg::KIND_EMPTY_ROW, 8'd0, 15'd0, 1'b0, 1'b1);
          phase        = drfd_pkg::PH_COUNT_HI;
          fields_total = '0;
          field_number = '0;
        end else begin
          fields_total = count[14:0];
          field_number = '0;
          hdr_pos      = '0;
          length_acc   = '0;
          phase        = drfd_pkg::PH_LENGTH;
        end
      end
      drfd_pkg::PH_LENGTH: begin
        length_acc = {length_acc[23:0], b};
        if (hdr_pos != 2'd3) begin
          hdr_pos = hdr_pos + 2'd1;
        end else begin
          hdr_pos = '0;
          if (length_acc == drfd_pkg::NULL_LENGTH || length_acc == 32'd0) begin
            last = on_last_field();
            queue_result((length_acc == 32'd0) ? drfd_pkg::KIND_EMPTY : drfd_pkg::KIND_NULL,
                         8'd0, field_number, 1'b1, last);
            close_field(last);
          end else begin
            remaining = length_acc;
            phase     = drfd_pkg::PH_PAYLOAD;
          end
        end
      end
      drfd_pkg::PH_PAYLOAD: begin
        last      = on_last_field();
        remaining = remaining - 32'd1;
        end_field = (remaining == 32'd0);
        queue_result(drfd_pkg::KIND_PAYLOAD, b, field_number, end_field,
                     end_field && last);
        if (end_field) close_field(last);
      end
      default: begin
        count_hi = b;
        phase    = drfd_pkg::PH_COUNT_LO;
      end
    endcase
  endfunction

  function void check_result(drfd_pkg::res_t got);
    drfd_pkg::res_t want;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("ERROR: unexpected result kind=%0d byte=%02h idx=%0d fl=%0b rl=%0b",
                 got.kind, got.out_byte, got.field_index, got.field_last,
                 got.row_last);
      return;
    end
    want = expected_q.pop_front();
    if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
        got.field_index !== want.field_index ||
        got.field_last !== want.field_last || got.row_last !== want.row_last) begin
      errors++;
      if (errors <= 10)
        $display("ERROR: result mismatch: expected kind=%0d byte=%02h idx=%0d fl=%0b rl=%0b",
                 want.kind, want.out_byte, want.field_index, want.field_last,
                 want.row_last,
                 ", got kind=%0d byte=%02h idx=%0d fl=%0b rl=%0b",
                 got.kind, got.out_byte, got.field_index, got.field_last,
                 got.row_last);
    end
  endfunction
endclass

module tb_data_row_field_deframer;

  // Generous ceiling: roughly 1300 requests, each of which could meet the
  // longest sender gap and the longest receiver stall, finish well within it.
  localparam int LIMIT_CYCLES = 400000;
  // Requests sent in total, directed part included, before the trailing noise.
  localparam int ITEM_BUDGET  = 1250;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [7:0]  in_tdata   = 8'd0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [23:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  row_scoreboard sb = new();

  // Bytes of the rows being built, waiting to be sent.
  logic [7:0] byte_q[$];
  int         items_sent;
  bit         calm_in;
  bit         calm_out;
  int         stall_left;
  int         cycles;

  data_row_field_deframer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #4 clk = ~clk;

  // Cycle counter; a run that hangs ends here.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("FAIL data_row_field_deframer");
      $finish;
    end
  end

  // Monitor. Inputs are noted before results are checked so that the order of
  // the two within one edge never matters. Both sample pre-edge values.
  always @(posedge clk) begin
    drfd_pkg::res_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_request(in_tdata);
      if (out_tvalid && out_tready) begin
        got.kind        = drfd_pkg::kind_t'(out_tuser[1:0]);
        got.out_byte    = out_tdata[7:0];
        got.field_index = out_tdata[22:8];
        got.field_last  = out_tuser[2];
        got.row_last    = out_tlast;
        sb.check_result(got);
      end
    end
  end

  // Receiver. Mostly ready, with short and occasional long stalls, and calm
  // stretches where it never stalls. The mode is redrawn periodically.
  always @(posedge clk) begin
    int r;
    if (cycles % 256 == 0) calm_out = ($urandom_range(0, 3) == 0);
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (calm_out) begin
      out_tready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_tready <= 1'b1;
      end else if (r < 95) begin
        stall_left = $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        stall_left = $urandom_range(5, 23);
        out_tready <= 1'b0;
      end
    end
  end

  function int pick_gap();
    int r;
    if (calm_in) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  function void push_count(logic [15:0] c);
    byte_q.push_back(c[15:8]);
    byte_q.push_back(c[7:0]);
  endfunction

  function void push_length(logic [31:0] len);
    byte_q.push_back(len[31:24]);
    byte_q.push_back(len[23:16]);
    byte_q.push_back(len[15:8]);
    byte_q.push_back(len[7:0]);
  endfunction

  function void push_payload(int n);
    repeat (n) byte_q.push_back(8'($urandom));
  endfunction

  // One field of a well-formed row: null, empty, or a short or longer payload.
  function void push_random_field();
    int r;
    int len;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      push_length(drfd_pkg::NULL_LENGTH);
    end else if (r < 30) begin
      push_length(32'd0);
    end else begin
      len = (r < 35) ? $urandom_range(13, 300) : $urandom_range(1, 12);
      push_length(32'(len));
      push_payload(len);
    end
  endfunction

  // Sends one byte. Called at a rising edge; the valid stays high from one
  // request to the next when there is no gap, so it is never lowered and
  // raised in the same step.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic send_queued();
    calm_in = ($urandom_range(0, 3) == 0);
    while (byte_q.size() != 0) send_byte(byte_q.pop_front());
  endtask

  // The sender holds off until every expected result has arrived.
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    int r;
    int nf;
    items_sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A zero count and two negative counts give empty row
    // markers.
    push_count(16'h0000);
    push_count(16'h8000);
    push_count(16'hFFFF);
    // Three fields: a null, an empty field and a two-byte payload that ends
    // the row.
    push_count(16'h0003);
    push_length(drfd_pkg::NULL_LENGTH);
    push_length(32'd0);
    push_length(32'd2);
    byte_q.push_back(8'h00);
    byte_q.push_back(8'hFF);
    // A single null field that is also the last field of its row.
    push_count(16'h0001);
    push_length(drfd_pkg::NULL_LENGTH);
    send_queued();
    wait_for_drain();

    // A row with more than 256 fields so that the upper bits of the field
    // index move. Its fields are mostly markers to keep it short.
    nf = 256 + $urandom_range(1, 3);
    push_count(16'(nf));
    repeat (nf) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        push_length(drfd_pkg::NULL_LENGTH);
      end else if (r < 90) begin
        push_length(32'd0);
      end else begin
        push_length(32'd2);
        push_payload(2);
      end
    end
    send_queued();

    // Random rows: mostly well-formed with random content, some empty and
    // negative counts, and now and then a full drain of the pipeline.
    while (items_sent < ITEM_BUDGET) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        push_count(16'h0000);
      end else if (r < 16) begin
        push_count({1'b1, 15'($urandom)});
      end else begin
        nf = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        push_count(16'(nf));
        repeat (nf) push_random_field();
      end
      send_queued();
      if ($urandom_range(0, 49) == 0) wait_for_drain();
    end

    // Trailing noise: unframed bytes, which may start rows that never end.
    push_payload(48);
    send_queued();

    wait_for_drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS data_row_field_deframer");
    end else begin
      $display("FAIL data_row_field_deframer");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/drfd_pkg.sv
sv/drfd_parser.sv
sv/drfd_out_reg.sv
sv/data_row_field_deframer.sv
dv/tb_data_row_field_deframer.sv
